// ===== hw/rtl/swfd_pkg.sv =====
// Shared types and constants for the sync word frame deframer.
// No dependencies.
package swfd_pkg;

  localparam logic [31:0] SYNC_RESET_VALUE = 32'h7FF0_1CAF;
  localparam int unsigned WORD_COUNT = 4;
  localparam logic [3:0] LAST_INDEX = 4'd15;
  localparam logic [2:0] FILL_FULL = 3'd4;

  typedef logic [7:0] byte_t;
  typedef logic [31:0] word_t;

  typedef struct packed {
    logic hunt;
    logic gather;
    logic restart;
  } swfd_step_t;

  typedef struct packed {
    word_t rate_z_bits;
    word_t rate_y_bits;
    word_t rate_x_bits;
    word_t frame_counter;
  } swfd_result_t;

endpackage

// ===== hw/rtl/swfd_hunt.sv =====
// Sync hunt: four-byte sliding window and compare against the sync word.
// Depends on swfd_pkg.
module swfd_hunt import swfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  swfd_step_t step,
  input  byte_t      data_byte,
  input  word_t      sync_word,
  output logic       match
);

  word_t      window_r, window_nxt;
  logic [2:0] fill_r, fill_nxt;

  always_comb begin
    window_nxt = window_r;
    fill_nxt   = fill_r;
    if (step.restart) begin
      window_nxt = '0;
      fill_nxt   = '0;
    end else if (step.hunt) begin
      window_nxt = {window_r[23:0], data_byte};
      if (fill_r < FILL_FULL) begin
        fill_nxt = fill_r + 3'd1;
      end
    end
  end

  assign match = step.hunt && (fill_nxt == FILL_FULL) && (window_nxt == sync_word);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      fill_r   <= '0;
    end else begin
      window_r <= window_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ===== hw/rtl/swfd_gather.sv =====
// Payload gather: assembles sixteen bytes into four big-endian words.
// Depends on swfd_pkg.
module swfd_gather import swfd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  swfd_step_t   step,
  input  byte_t        data_byte,
  output logic         last,
  output swfd_result_t result
);

  logic [3:0] index_r, index_nxt;
  word_t      words_r [WORD_COUNT];
  logic [1:0] slot;

  assign slot      = index_r[3:2];
  assign index_nxt = index_r + 4'd1;
  assign last      = step.gather && (index_r == LAST_INDEX);

  // Final word completes with the current byte
  assign result.frame_counter = words_r[0];
  assign result.rate_x_bits   = words_r[1];
  assign result.rate_y_bits   = words_r[2];
  assign result.rate_z_bits   = {words_r[3][23:0], data_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r <= '0;
    end else if (step.gather) begin
      index_r <= index_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step.gather) begin
      words_r[slot] <= {words_r[slot][23:0], data_byte};
    end
  end

endmodule

// ===== hw/rtl/sync_word_frame_deframer.sv =====
// Sync word frame deframer top: input register, hunt and gather, result register.
// Depends on swfd_pkg, swfd_hunt and swfd_gather.
// out_tvalid rises after the last payload byte passes the input and result registers.
// Throughput: one byte per cycle; a result waiting for out_tready holds the input.
// Reset: sync word returns to 0x7FF01CAF, the block starts hunting with an empty window.
// The payload word store is not cleared; every word is written before it is read.
module sync_word_frame_deframer import swfd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [31:0] frame_counter, [63:32] rate_x_bits,
                                   // [95:64] rate_y_bits, [127:96] rate_z_bits
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  word_t        sync_word_r;
  logic         in_valid_r;
  byte_t        in_byte_r;
  logic         in_frame_r, in_frame_nxt;
  logic         out_valid_r;
  swfd_result_t out_data_r;

  logic         advance;
  logic         process;
  logic         hunt_match;
  logic         gather_last;
  logic         res_load;
  swfd_step_t   step;
  swfd_result_t result;

  assign cfg_ready = 1'b1;

  assign advance   = !out_valid_r || out_tready;
  assign process   = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  assign step.hunt    = process && !in_frame_r;
  assign step.gather  = process && in_frame_r;
  assign step.restart = gather_last;
  assign res_load     = gather_last;

  always_comb begin
    in_frame_nxt = in_frame_r;
    if (hunt_match) begin
      in_frame_nxt = 1'b1;
    end else if (gather_last) begin
      in_frame_nxt = 1'b0;
    end
  end

  swfd_hunt u_hunt (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .sync_word (sync_word_r),
    .match     (hunt_match)
  );

  swfd_gather u_gather (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .last      (gather_last),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r <= SYNC_RESET_VALUE;
      in_valid_r  <= 1'b0;
      in_frame_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sync_word_r <= cfg_data;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      in_frame_r <= in_frame_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (res_load) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_no_match_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    !(hunt_match && gather_last))
    else $error("sync match and frame end in the same cycle");

  a_load_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (in_frame_r && process))
    else $error("result loaded outside a frame");

  a_hunt_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> !in_frame_r)
    else $error("frame not closed after result");

  a_frame_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_frame_r) |-> $past(hunt_match))
    else $error("frame entered without sync match");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !res_load)
    else $error("pending result overwritten");

endmodule
